@@ hw/rtl/lhtid_pkg.sv @@
// Shared types and operation codes for the bounded list block.
// No dependencies; compile first.
`default_nettype none

package lhtid_pkg;

    // Operation selector of an input transaction
    typedef logic [1:0] func_t;

    localparam func_t FUNC_INS_FRONT = 2'd0;
    localparam func_t FUNC_INS_BACK  = 2'd1;
    localparam func_t FUNC_DELETE    = 2'd2;

    // Payload field types
    typedef logic signed [31:0] elem_t;
    typedef logic [7:0]         pos_t;

endpackage

`default_nettype wire

@@ hw/rtl/lhtid_if.sv @@
// Valid/ready channel interfaces for the bounded list block.
// Depends on lhtid_pkg for the payload field types.
`default_nettype none

// Command channel: one operation per transaction
interface lhtid_in_if;
    logic               valid;
    logic               ready;
    lhtid_pkg::func_t   func;
    lhtid_pkg::elem_t   value;
    lhtid_pkg::pos_t    position;

    modport source (output valid, output func, output value, output position, input ready);
    modport sink   (input valid, input func, input value, input position, output ready);
endinterface

// Dump channel: one list element per transaction
interface lhtid_out_if;
    logic               valid;
    logic               ready;
    lhtid_pkg::elem_t   element;
    logic               last;
    logic               empty_res;
    logic               dropped;

    modport source (output valid, output element, output last, output empty_res,
                    output dropped, input ready);
    modport sink   (input valid, input element, input last, input empty_res,
                    input dropped, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/list_head_tail_insert_index_delete.sv @@
// Bounded ordered list with front/back insert and indexed delete.
// Depends on lhtid_pkg and the channel interfaces in lhtid_if.sv.
//
//   channel | dir | payload                              | handshake
//   cmd     | in  | func, value, position                | valid/ready
//   dump    | out | element, last, empty_res, dropped    | valid/ready
//
// Storage is a circular buffer in a one-write, one-read memory; a head pointer
// makes front insert and delete at position zero updates that move no elements.
// Each command has an update step; a delete that closes a gap then reads and
// writes each element moved one place forward (n - pos - 1 elements); then the
// list is dumped, one transaction per element (n, or 1 for an empty list). The
// memory read port sets the dump rate. Reset clears the control registers only;
// memory contents need no clearing. A stalled dump holds the current element;
// the next command is taken while the final element still waits.
`default_nettype none

module list_head_tail_insert_index_delete #(
    parameter int DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    lhtid_in_if.sink         cmd,
    lhtid_out_if.source      dump
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SH_RD = 2'd1;
    localparam logic [1:0] S_SH_WR = 2'd2;
    localparam logic [1:0] S_DUMP  = 2'd3;

    // Add an offset to a buffer pointer, wrapping at DEPTH
    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] base,
                                               input logic [PW-1:0] off);
        logic [PW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (PW+1)'(DEPTH))
            sum = sum - (PW+1)'(DEPTH);
        return sum[PW-1:0];
    endfunction

    logic [1:0]        state_reg, state_next;
    logic [PW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [PW-1:0]     idx_reg, idx_next;
    logic              drop_reg, drop_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_last_reg, out_last_next;
    logic              out_empty_reg, out_empty_next;
    logic              out_drop_reg, out_drop_next;

    lhtid_pkg::elem_t  mem [DEPTH];
    lhtid_pkg::elem_t  rd_data_reg;
    logic              wr_en, rd_en;
    logic [PW-1:0]     wr_addr, rd_addr;
    lhtid_pkg::elem_t  wr_data;

    logic              cmd_accept;
    logic              slot_free;
    logic              pos_ok;
    logic              is_last;

    assign cmd.ready  = (state_reg == S_IDLE);
    assign cmd_accept = cmd.valid && cmd.ready;
    assign slot_free  = !out_valid_reg || dump.ready;
    assign pos_ok     = (CW+8)'(cmd.position) < (CW+8)'(count_reg);
    assign is_last    = (CW'(idx_reg) + CW'(1)) == count_reg;

    assign dump.valid     = out_valid_reg;
    assign dump.element   = out_empty_reg ? '0 : rd_data_reg;
    assign dump.last      = out_last_reg;
    assign dump.empty_res = out_empty_reg;
    assign dump.dropped   = out_drop_reg;

    // Sequencer: update, close the gap, then walk the list out
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        drop_next      = drop_reg;
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;
        out_drop_next  = out_drop_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = cmd.value;
        rd_en          = 1'b0;
        rd_addr        = '0;

        // Drop the held element once taken
        if (out_valid_reg && dump.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_accept)
                begin
                    drop_next  = 1'b0;
                    idx_next   = '0;
                    state_next = S_DUMP;
                    if (cmd.func == lhtid_pkg::FUNC_INS_FRONT ||
                        cmd.func == lhtid_pkg::FUNC_INS_BACK)
                    begin
                        if (count_reg == CW'(DEPTH))
                            drop_next = 1'b1;
                        else if (cmd.func == lhtid_pkg::FUNC_INS_FRONT)
                        begin
                            head_next  = (head_reg == '0) ? PW'(DEPTH - 1)
                                                          : head_reg - PW'(1);
                            wr_en      = 1'b1;
                            wr_addr    = head_next;
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = wrap_add(head_reg, count_reg[PW-1:0]);
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else if (pos_ok)
                    begin
                        count_next = count_reg - CW'(1);
                        if (cmd.position == '0)
                            head_next = wrap_add(head_reg, PW'(1));
                        else if ((CW+8)'(cmd.position) < (CW+8)'(count_next))
                        begin
                            idx_next   = cmd.position[PW-1:0];
                            state_next = S_SH_RD;
                        end
                    end
                end
            end

            S_SH_RD:
            begin
                // Wait for the read register to be free of a held element
                if (!out_valid_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = wrap_add(head_reg, idx_reg + PW'(1));
                    state_next = S_SH_WR;
                end
            end

            S_SH_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = wrap_add(head_reg, idx_reg);
                wr_data = rd_data_reg;
                if (is_last)
                begin
                    idx_next   = '0;
                    state_next = S_DUMP;
                end
                else
                begin
                    idx_next   = idx_reg + PW'(1);
                    state_next = S_SH_RD;
                end
            end

            S_DUMP:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_drop_next  = drop_reg;
                    if (count_reg == '0)
                    begin
                        out_empty_next = 1'b1;
                        out_last_next  = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        rd_en          = 1'b1;
                        rd_addr        = wrap_add(head_reg, idx_reg);
                        out_empty_next = 1'b0;
                        out_last_next  = is_last;
                        if (is_last)
                            state_next = S_IDLE;
                        else
                            idx_next = idx_reg + PW'(1);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output flag payload
    always_ff @(posedge clk)
    begin
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
        out_drop_reg  <= out_drop_next;
    end

    // List storage: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for the bounded list block: front/back insert and indexed delete.
// Depends on lhtid_pkg, lhtid_if.sv and list_head_tail_insert_index_delete.sv.
`timescale 1ns / 100ps

module testbench;

    localparam int    LIST_DEPTH       = 16;
    localparam int    CLK_HALF_NS      = 6;
    localparam int    RESET_CYCLES     = 7;
    localparam int    RANDOM_ITEMS     = 205;
    localparam int    LONG_HOLD_CYCLES = 400;
    localparam int    SETTLE_CYCLES    = 64;
    localparam int    TIMEOUT_NS       = 6_000_000;
    // Selector 3 behaves as a delete at position
    localparam lhtid_pkg::func_t FUNC_DELETE_ALT = 2'd3;
    localparam lhtid_pkg::elem_t ELEM_MAX        = 32'sh7FFF_FFFF;
    localparam lhtid_pkg::elem_t ELEM_MIN        = 32'sh8000_0000;

    // One expected transaction on the dump channel
    typedef struct packed {
        lhtid_pkg::elem_t element;
        logic             last;
        logic             empty_res;
        logic             dropped;
    } dump_beat_t;

    // Mirror of the list contents and the queue of dump transactions still owed
    class dump_scoreboard;
        lhtid_pkg::elem_t contents[$];
        dump_beat_t       owed[$];
        int               mismatches;
        int               n_commands;
        int               n_beats;
        int               n_refused;
        int               n_empty;

        function new();
            mismatches = 0;
            n_commands = 0;
            n_beats    = 0;
            n_refused  = 0;
            n_empty    = 0;
        endfunction

        function int size();
            return contents.size();
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // Apply one accepted command to the mirror and queue the whole dump it causes
        function void note_command(lhtid_pkg::func_t op, lhtid_pkg::elem_t val,
                                   lhtid_pkg::pos_t pos);
            logic       refused;
            dump_beat_t beat;
            refused = 1'b0;
            n_commands++;
            case (op)
                lhtid_pkg::FUNC_INS_FRONT, lhtid_pkg::FUNC_INS_BACK:
                begin
                    if (contents.size() >= LIST_DEPTH)
                        refused = 1'b1;
                    else if (op == lhtid_pkg::FUNC_INS_FRONT)
                        contents.push_front(val);
                    else
                        contents.push_back(val);
                end
                default:
                begin
                    if (int'(pos) < contents.size())
                        contents.delete(int'(pos));
                end
            endcase
            if (refused)
                n_refused++;
            if (contents.size() == 0)
            begin
                beat.element   = '0;
                beat.last      = 1'b1;
                beat.empty_res = 1'b1;
                beat.dropped   = refused;
                owed.push_back(beat);
                n_empty++;
            end
            else
            begin
                for (int i = 0; i < contents.size(); i++)
                begin
                    beat.element   = contents[i];
                    beat.last      = (i == contents.size() - 1);
                    beat.empty_res = 1'b0;
                    beat.dropped   = refused;
                    owed.push_back(beat);
                end
            end
        endfunction

        function void flag(string field, logic [31:0] exp_v, logic [31:0] act_v);
            mismatches++;
            $error("dump %s: expected %0d, got %0d", field, $signed(exp_v), $signed(act_v));
        endfunction

        // Compare one accepted dump transaction with the oldest owed one
        function void check_dump(lhtid_pkg::elem_t element, logic last, logic empty_res,
                                 logic dropped);
            dump_beat_t exp_b;
            n_beats++;
            if (owed.size() == 0)
            begin
                mismatches++;
                $error("dump transaction with nothing owed: element %0d", element);
                return;
            end
            exp_b = owed.pop_front();
            if (element !== exp_b.element)
                flag("element", exp_b.element, element);
            if (last !== exp_b.last)
                flag("last", {31'd0, exp_b.last}, {31'd0, last});
            if (empty_res !== exp_b.empty_res)
                flag("empty_res", {31'd0, exp_b.empty_res}, {31'd0, empty_res});
            if (dropped !== exp_b.dropped)
                flag("dropped", {31'd0, exp_b.dropped}, {31'd0, dropped});
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   quiet;
    bit   hold_request;

    dump_scoreboard sb;

    lhtid_in_if  cmd_ch ();
    lhtid_out_if dump_ch ();

    list_head_tail_insert_index_delete #(
        .DEPTH (LIST_DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .dump  (dump_ch)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF_NS) clk = ~clk;
    end

    // Abandon a run that hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

    // Observe both channels at the clock edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (dump_ch.valid && dump_ch.ready)
                sb.check_dump(dump_ch.element, dump_ch.last, dump_ch.empty_res,
                              dump_ch.dropped);
            if (cmd_ch.valid && cmd_ch.ready)
                sb.note_command(cmd_ch.func, cmd_ch.value, cmd_ch.position);
        end
    end

    // Dump receiver: random stall bursts, long hold on request, no random stalls when quiet
    initial
    begin : dump_receiver
        int   stall_left;
        int   run_left;
        int   hold_left;
        bit   hold_taken;
        logic rdy;
        stall_left = 0;
        run_left   = 0;
        hold_left  = 0;
        hold_taken = 1'b0;
        dump_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_request && !hold_taken)
            begin
                hold_left  = LONG_HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (quiet)
                rdy = 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                rdy = 1'b0;
            end
            else if (run_left > 0)
            begin
                run_left--;
                rdy = 1'b1;
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                stall_left = $urandom_range(1, 15) - 1;
                rdy = 1'b0;
            end
            else
            begin
                run_left = $urandom_range(1, 30) - 1;
                rdy = 1'b1;
            end
            dump_ch.ready <= rdy;
            @(posedge clk);
        end
    end

    function automatic int pick_gap();
        if (quiet || $urandom_range(0, 3) != 0)
            return 0;
        return $urandom_range(1, 15);
    endfunction

    function automatic lhtid_pkg::elem_t pick_value();
        case ($urandom_range(0, 7))
            0:       return ELEM_MAX;
            1:       return ELEM_MIN;
            2:       return lhtid_pkg::elem_t'($urandom_range(0, 15));
            default: return lhtid_pkg::elem_t'($urandom);
        endcase
    endfunction

    // Offer one command, optionally after an idle gap, and hold until it is taken
    task automatic send_command(lhtid_pkg::func_t op, lhtid_pkg::elem_t val,
                                lhtid_pkg::pos_t pos);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.func     <= op;
        cmd_ch.value    <= val;
        cmd_ch.position <= pos;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
    endtask

    // Random command; insert_pct biases the list towards full or empty
    task automatic send_random(int insert_pct);
        lhtid_pkg::func_t op;
        lhtid_pkg::elem_t val;
        lhtid_pkg::pos_t  pos;
        int               cur;
        cur = sb.size();
        val = pick_value();
        pos = lhtid_pkg::pos_t'($urandom);
        if ($urandom_range(0, 99) < insert_pct)
            op = ($urandom_range(0, 1) != 0) ? lhtid_pkg::FUNC_INS_BACK
                                             : lhtid_pkg::FUNC_INS_FRONT;
        else
        begin
            op = ($urandom_range(0, 7) == 0) ? FUNC_DELETE_ALT : lhtid_pkg::FUNC_DELETE;
            if (cur > 0 && $urandom_range(0, 3) != 0)
                pos = lhtid_pkg::pos_t'($urandom_range(0, cur - 1));
        end
        send_command(op, val, pos);
    endtask

    // Hold the command side idle until every owed dump transaction has arrived
    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin : main_sequence
        int insert_pct;
        sb           = new();
        quiet        = 1'b0;
        hold_request = 1'b0;
        rst_n        = 1'b0;
        cmd_ch.valid    <= 1'b0;
        cmd_ch.func     <= lhtid_pkg::FUNC_INS_FRONT;
        cmd_ch.value    <= '0;
        cmd_ch.position <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: deletes on an empty list, extreme values, out-of-range deletes
        send_command(lhtid_pkg::FUNC_DELETE, pick_value(), 8'd0);
        send_command(FUNC_DELETE_ALT, pick_value(), 8'd255);
        send_command(lhtid_pkg::FUNC_INS_FRONT, ELEM_MAX, lhtid_pkg::pos_t'($urandom));
        send_command(lhtid_pkg::FUNC_INS_BACK, ELEM_MIN, lhtid_pkg::pos_t'($urandom));
        send_command(lhtid_pkg::FUNC_INS_FRONT, -32'sd1, lhtid_pkg::pos_t'($urandom));
        send_command(lhtid_pkg::FUNC_INS_BACK, 32'sd0, lhtid_pkg::pos_t'($urandom));
        send_command(lhtid_pkg::FUNC_DELETE, pick_value(), 8'd4);
        send_command(FUNC_DELETE_ALT, pick_value(), 8'd1);
        // Fill to capacity, then push against the full list from both ends
        for (int i = 0; i < LIST_DEPTH - 3; i++)
            send_command((i % 2 == 0) ? lhtid_pkg::FUNC_INS_FRONT : lhtid_pkg::FUNC_INS_BACK,
                         pick_value(), lhtid_pkg::pos_t'($urandom));
        send_command(lhtid_pkg::FUNC_INS_FRONT, pick_value(), lhtid_pkg::pos_t'($urandom));
        send_command(lhtid_pkg::FUNC_INS_BACK, pick_value(), lhtid_pkg::pos_t'($urandom));
        send_command(lhtid_pkg::FUNC_DELETE, pick_value(), lhtid_pkg::pos_t'(LIST_DEPTH - 1));
        send_command(lhtid_pkg::FUNC_DELETE, pick_value(), 8'd0);
        wait_drained();

        // Random: phases that lean towards filling, emptying, or neither
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            case ((k / 30) % 3)
                0:       insert_pct = 85;
                1:       insert_pct = 25;
                default: insert_pct = 55;
            endcase
            if (k == 70)
            begin
                // Block the dump side while commands keep coming back to back
                quiet        = 1'b1;
                hold_request = 1'b1;
            end
            if (k == 90)
                quiet = 1'b0;
            if (k == 140)
                wait_drained();
            if (k == RANDOM_ITEMS - 40)
                quiet = 1'b1;
            send_random(insert_pct);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d commands and %0d dump transactions", sb.n_commands, sb.n_beats);
        $display("including %0d refused inserts and %0d empty-list dumps",
                 sb.n_refused, sb.n_empty);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
